// ----- design/ray_sphere_light_hit_unit_assert.svh -----
// ============================================================================
// Assertion macros for the ray/sphere light hit unit
// Shared property shapes used by the port checker.
// ============================================================================
`ifndef RAY_SPHERE_LIGHT_HIT_UNIT_ASSERT_SVH
`define RAY_SPHERE_LIGHT_HIT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RSL_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RSL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rsl_pkg.sv -----
// ============================================================================
// rsl_pkg
// Widths, register indexes and stage payload types of the sphere light unit.
// ============================================================================
`default_nettype none

package rsl_pkg;

	localparam int PosW   = 24;          // Q16.8 position
	localparam int DirW   = 16;          // Q2.14 direction
	localparam int ColW   = 16;          // Q0.16 color
	localparam int RadW   = 23;          // Q15.8 radius
	localparam int TW     = 32;          // Q16.16 distance, also quotient bits
	localparam int InW    = 3 * PosW + 3 * DirW;
	localparam int OutW   = TW + 3 * ColW;
	localparam int SqW    = 43;          // root bits
	localparam int SqRemW = 87;          // root remainder / trial width
	localparam int NumW   = 45;          // root numerator
	localparam int DivW   = NumW + 22;   // dividend num * 2^22

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_CENTER_Z  = 3'd2,
		REG_RADIUS    = 3'd3,
		REG_RED       = 3'd4,
		REG_GREEN     = 3'd5,
		REG_BLUE      = 3'd6,
		REG_INTENSITY = 3'd7
	} cfg_reg_t;

	// side data riding along the square root stages
	typedef struct packed {
		logic signed [42:0] h;
		logic [31:0]        a;
		logic               near;
		logic               far;
		logic               miss;
	} sq_side_t;

	// side data riding along the divider stages
	typedef struct packed {
		logic [31:0]     a;
		logic            hit;
		logic            sat;
		logic [ColW-1:0] red;
		logic [ColW-1:0] green;
		logic [ColW-1:0] blue;
	} dv_side_t;

endpackage

`default_nettype wire

// ----- design/ray_sphere_light_hit_unit.sv -----
// One ray is accepted per cycle while the output is not held.
// The 43-stage root and 32-stage divider pipelines carry one bit per stage.
// A held result (m_tready low) freezes every stage; nothing is dropped.
// Reset clears all stage valid bits and loads the register reset values.
// ============================================================================
// ray_sphere_light_hit_unit
// Pipelined ray against spherical light intersection with emitted color.
// ============================================================================
`default_nettype none

module ray_sphere_light_hit_unit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  wire logic [rsl_pkg::InW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// hit_distance, out_red, out_green, out_blue
	output logic [rsl_pkg::OutW-1:0]      m_tdata,
	// hit
	output logic [0:0]                    m_tuser,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_addr,
	input  wire logic [rsl_pkg::PosW-1:0] cfg_wdata
);
	import rsl_pkg::*;

	// saturating color from the split product p * s / 2^30
	function automatic logic [ColW-1:0] shade_sat(input logic [52:0] hi,
		input logic [53:0] lo);
		logic [74:0] prod;
		prod = (75'(hi) << 22) + 75'(lo);
		shade_sat = (|prod[74:46]) ? {ColW{1'b1}} : prod[45:30];
	endfunction

	logic adv;

	// ------------------------------------------------------------------
	// configuration registers
	logic signed [PosW-1:0] cx_q, cy_q, cz_q;
	logic [RadW-1:0]        rad_q;
	logic [ColW-1:0]        red_q, green_q, blue_q, inten_q;
	logic [45:0]            rad2_q;
	logic [31:0]            pr_q, pg_q, pb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
			rad_q   <= RadW'(256);
			red_q   <= '1;
			green_q <= '1;
			blue_q  <= '1;
			inten_q <= ColW'(256);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CENTER_X:  cx_q    <= cfg_wdata;
				REG_CENTER_Y:  cy_q    <= cfg_wdata;
				REG_CENTER_Z:  cz_q    <= cfg_wdata;
				REG_RADIUS:    rad_q   <= cfg_wdata[RadW-1:0];
				REG_RED:       red_q   <= cfg_wdata[ColW-1:0];
				REG_GREEN:     green_q <= cfg_wdata[ColW-1:0];
				REG_BLUE:      blue_q  <= cfg_wdata[ColW-1:0];
				REG_INTENSITY: inten_q <= cfg_wdata[ColW-1:0];
				default: ;
			endcase
		end
	end

	// derived constants, settle long before any ray needs them
	always_ff @(posedge clk) begin
		rad2_q <= rad_q * rad_q;
		pr_q   <= red_q * inten_q;
		pg_q   <= green_q * inten_q;
		pb_q   <= blue_q * inten_q;
	end

	// ------------------------------------------------------------------
	// stall control: whole pipe moves unless the output is held
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// stage 1: n = center - origin
	logic                   v_s1;
	logic signed [24:0]     nx_s1, ny_s1, nz_s1;
	logic signed [DirW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PosW-1:0] ox, oy, oz;

	assign ox = s_tdata[23:0];
	assign oy = s_tdata[47:24];
	assign oz = s_tdata[71:48];

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= {cx_q[PosW-1], cx_q} - {ox[PosW-1], ox};
			ny_s1 <= {cy_q[PosW-1], cy_q} - {oy[PosW-1], oy};
			nz_s1 <= {cz_q[PosW-1], cz_q} - {oz[PosW-1], oz};
			dx_s1 <= s_tdata[87:72];
			dy_s1 <= s_tdata[103:88];
			dz_s1 <= s_tdata[119:104];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: component products
	logic               v_s2;
	logic signed [40:0] hx_c, hy_c, hz_c;
	logic signed [31:0] axx_c, ayy_c, azz_c;
	logic signed [49:0] nxx_c, nyy_c, nzz_c;
	logic signed [40:0] hx_s2, hy_s2, hz_s2;
	logic [30:0]        ax_s2, ay_s2, az_s2;
	logic [48:0]        nnx_s2, nny_s2, nnz_s2;

	assign hx_c  = nx_s1 * dx_s1;
	assign hy_c  = ny_s1 * dy_s1;
	assign hz_c  = nz_s1 * dz_s1;
	assign axx_c = dx_s1 * dx_s1;
	assign ayy_c = dy_s1 * dy_s1;
	assign azz_c = dz_s1 * dz_s1;
	assign nxx_c = nx_s1 * nx_s1;
	assign nyy_c = ny_s1 * ny_s1;
	assign nzz_c = nz_s1 * nz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s2  <= hx_c;
			hy_s2  <= hy_c;
			hz_s2  <= hz_c;
			ax_s2  <= axx_c[30:0];
			ay_s2  <= ayy_c[30:0];
			az_s2  <= azz_c[30:0];
			nnx_s2 <= nxx_c[48:0];
			nny_s2 <= nyy_c[48:0];
			nnz_s2 <= nzz_c[48:0];
		end
	end

	// ------------------------------------------------------------------
	// stage 3: h = dot(d, n), a = dot(d, d), c = dot(n, n) - r^2
	logic               v_s3;
	logic signed [42:0] h_s3;
	logic [31:0]        a_s3;
	logic signed [50:0] c_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s3 <= {{2{hx_s2[40]}}, hx_s2} + {{2{hy_s2[40]}}, hy_s2}
				+ {{2{hz_s2[40]}}, hz_s2};
			a_s3 <= {1'b0, ax_s2} + {1'b0, ay_s2} + {1'b0, az_s2};
			c_s3 <= {2'b0, nnx_s2} + {2'b0, nny_s2} + {2'b0, nnz_s2}
				- {5'b0, rad2_q};
		end
	end

	// ------------------------------------------------------------------
	// stage 4: partial products of h^2 and a*|c|
	logic               v_s4;
	logic [42:0]        habs_c;
	logic [50:0]        cabs_c;
	logic [41:0]        hhh_s4, hhl_s4, hll_s4;
	logic [57:0]        ach_s4;
	logic [56:0]        acl_s4;
	logic signed [42:0] h_s4;
	logic [31:0]        a_s4;
	logic               cpos_s4, cneg_s4;

	assign habs_c = h_s3[42] ? 43'(-h_s3) : 43'(h_s3);
	assign cabs_c = c_s3[50] ? 51'(-c_s3) : 51'(c_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			hhh_s4  <= habs_c[41:21] * habs_c[41:21];
			hhl_s4  <= habs_c[41:21] * habs_c[20:0];
			hll_s4  <= habs_c[20:0] * habs_c[20:0];
			ach_s4  <= a_s3 * cabs_c[50:25];
			acl_s4  <= a_s3 * cabs_c[24:0];
			h_s4    <= h_s3;
			a_s4    <= a_s3;
			cpos_s4 <= !c_s3[50] && (c_s3 != '0);
			cneg_s4 <= c_s3[50];
		end
	end

	// ------------------------------------------------------------------
	// stage 5: sum partials
	logic               v_s5;
	logic [83:0]        h2_s5;
	logic [82:0]        ac_s5;
	logic signed [42:0] h_s5;
	logic [31:0]        a_s5;
	logic               cpos_s5, cneg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			h2_s5   <= (84'(hhh_s4) << 42) + (84'(hhl_s4) << 22) + 84'(hll_s4);
			ac_s5   <= (83'(ach_s4) << 25) + 83'(acl_s4);
			h_s5    <= h_s4;
			a_s5    <= a_s4;
			cpos_s5 <= cpos_s4;
			cneg_s5 <= cneg_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: discriminant, root choice; feeds the root pipe at index 0
	logic [84:0]     disc_c;
	logic            dneg_c, hpos_c, hzero_c, near_c, far_c;
	logic            sq_v   [0:SqW];
	logic [SqRemW-1:0] sq_rem [0:SqW];
	logic [SqW-1:0]  sq_root [0:SqW];
	sq_side_t        sq_side [0:SqW];

	always_comb begin
		disc_c  = cpos_s5 ? (85'(h2_s5) - 85'(ac_s5)) : (85'(h2_s5) + 85'(ac_s5));
		dneg_c  = cpos_s5 && (84'(ac_s5) > h2_s5);
		hzero_c = (h_s5 == '0);
		hpos_c  = !h_s5[42] && !hzero_c;
		near_c  = hpos_c && cpos_s5;
		far_c   = hpos_c || (hzero_c && (disc_c != '0)) || (h_s5[42] && cneg_s5);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem[0]       <= SqRemW'(disc_c);
			sq_root[0]      <= '0;
			sq_side[0].h    <= h_s5;
			sq_side[0].a    <= a_s5;
			sq_side[0].near <= near_c;
			sq_side[0].far  <= far_c;
			sq_side[0].miss <= (a_s5 == '0) || dneg_c || !(near_c || far_c);
		end
	end

	// ------------------------------------------------------------------
	// square root, one result bit per stage, high bit first
	for (genvar k = 0; k < SqW; k++) begin : g_sqrt
		localparam int B = SqW - 1 - k;
		logic [SqRemW-1:0] trial;

		assign trial = (SqRemW'(sq_root[k]) << (B + 1)) | (SqRemW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side[k+1] <= sq_side[k];
				if (sq_rem[k] >= trial) begin
					sq_rem[k+1]  <= sq_rem[k] - trial;
					sq_root[k+1] <= sq_root[k] | (SqW'(1) << B);
				end else begin
					sq_rem[k+1]  <= sq_rem[k];
					sq_root[k+1] <= sq_root[k];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 7: numerator, saturation test, shading partial products
	logic              v_s7;
	logic [SqW-1:0]    s_c;
	sq_side_t          sd_c;
	logic [NumW-1:0]   num_c;
	logic [NumW-1:0]   num_s7;
	logic [31:0]       a_s7;
	logic              sat_s7, near_s7, miss_s7;
	logic [52:0]       rhi_s7, ghi_s7, bhi_s7;
	logic [53:0]       rlo_s7, glo_s7, blo_s7;

	assign s_c  = sq_root[SqW];
	assign sd_c = sq_side[SqW];
	assign num_c = sd_c.near ? ({{2{sd_c.h[42]}}, sd_c.h} - {2'b0, s_c})
		: ({{2{sd_c.h[42]}}, sd_c.h} + {2'b0, s_c});

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7  <= num_c;
			a_s7    <= sd_c.a;
			sat_s7  <= num_c >= (NumW'(sd_c.a) << 10);
			near_s7 <= sd_c.near;
			miss_s7 <= sd_c.miss;
			rhi_s7  <= pr_q * s_c[42:22];
			rlo_s7  <= pr_q * s_c[21:0];
			ghi_s7  <= pg_q * s_c[42:22];
			glo_s7  <= pg_q * s_c[21:0];
			bhi_s7  <= pb_q * s_c[42:22];
			blo_s7  <= pb_q * s_c[21:0];
		end
	end

	// ------------------------------------------------------------------
	// stage 8: colors; feeds the divider at index 0
	logic            dv_v    [0:TW];
	logic [DivW-1:0] dv_rem  [0:TW];
	logic [TW-1:0]   dv_quo  [0:TW];
	dv_side_t        dv_side [0:TW];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem[0]        <= {num_s7, 22'b0};
			dv_quo[0]        <= '0;
			dv_side[0].a     <= a_s7;
			dv_side[0].hit   <= !miss_s7;
			dv_side[0].sat   <= sat_s7;
			dv_side[0].red   <= near_s7 ? shade_sat(rhi_s7, rlo_s7) : '0;
			dv_side[0].green <= near_s7 ? shade_sat(ghi_s7, glo_s7) : '0;
			dv_side[0].blue  <= near_s7 ? shade_sat(bhi_s7, blo_s7) : '0;
		end
	end

	// ------------------------------------------------------------------
	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < TW; k++) begin : g_div
		localparam int Q = TW - 1 - k;
		logic [DivW-1:0] dsub;

		assign dsub = DivW'(dv_side[k].a) << Q;

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side[k+1] <= dv_side[k];
				if (dv_rem[k] >= dsub) begin
					dv_rem[k+1] <= dv_rem[k] - dsub;
					dv_quo[k+1] <= dv_quo[k] | (TW'(1) << Q);
				end else begin
					dv_rem[k+1] <= dv_rem[k];
					dv_quo[k+1] <= dv_quo[k];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s7 <= sq_v[SqW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			sq_v[0] <= v_s5;
			dv_v[0] <= v_s7;
		end
	end

	for (genvar k = 0; k < SqW; k++) begin : g_sqv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end
	end

	for (genvar k = 0; k < TW; k++) begin : g_dvv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// result: zero everything on a miss
	dv_side_t      last_c;
	logic [TW-1:0] dist_c;

	assign last_c   = dv_side[TW];
	assign dist_c   = last_c.sat ? {TW{1'b1}} : dv_quo[TW];
	assign m_tvalid = dv_v[TW];
	assign m_tuser  = last_c.hit;
	assign m_tdata  = last_c.hit ? {last_c.blue, last_c.green, last_c.red, dist_c}
		: '0;

endmodule

`default_nettype wire

// ----- design/rsl_checker.sv -----
// ============================================================================
// rsl_checker
// Port-level checks of the sphere light unit, bound to the top level.
// ============================================================================
`default_nettype none

`include "ray_sphere_light_hit_unit_assert.svh"

module rsl_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [rsl_pkg::OutW-1:0]  m_tdata,
	input wire logic [0:0]                m_tuser
);
	import rsl_pkg::*;

	// a held result stays offered
	`RSL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while held")

	// a miss carries no distance and no color
	`RSL_ASSERT_IMPL(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero payload")

	// a held result blocks new requests
	`RSL_ASSERT_IMPL(a_stall_blocks, clk, arst_n, m_tvalid && !m_tready, !s_tready, "request taken during output stall")

endmodule

bind ray_sphere_light_hit_unit rsl_checker u_rsl_checker (.*);

`default_nettype wire

// ----- tb/tb_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_checker
// Watches the ray request and hit result streams and the register port,
// computes the expected hit record for every accepted ray in exact integer
// arithmetic, and compares each result with the oldest expected record.
// ============================================================================
`default_nettype none

module tb_checker (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tready,
	input  wire logic [rsl_pkg::InW-1:0]  s_tdata,
	input  wire logic                     m_tvalid,
	input  wire logic                     m_tready,
	input  wire logic [rsl_pkg::OutW-1:0] m_tdata,
	input  wire logic [0:0]               m_tuser,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_addr,
	input  wire logic [rsl_pkg::PosW-1:0] cfg_wdata,
	output int                            fail_count,
	output int                            pending
);
	import rsl_pkg::*;

	// same bit order as {m_tuser, m_tdata}
	typedef struct packed {
		logic        hit;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
		logic [31:0] distance;
	} hit_rec_t;

	// local copy of the light registers
	logic signed [23:0] cen_x, cen_y, cen_z;
	logic [22:0]        radius;
	logic [15:0]        col_r, col_g, col_b, gain;

	hit_rec_t hits_due[$];

	// floor square root of a non-negative value, 44 result bits
	function automatic logic [43:0] root_floor(input logic [127:0] v);
		logic [43:0]  r;
		logic [127:0] cand;
		r = '0;
		for (int i = 43; i >= 0; i--) begin
			cand = r | (44'd1 << i);
			if (cand * cand <= v) r = r | (44'd1 << i);
		end
		return r;
	endfunction

	function automatic logic [15:0] tint(input logic [15:0] col, input logic [43:0] s);
		logic [127:0] p;
		p = ({112'd0, col} * {112'd0, gain} * {84'd0, s}) >> 30;
		return (p > 128'hFFFF) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic hit_rec_t trace_light(input logic [InW-1:0] d);
		hit_rec_t           rec;
		logic signed [127:0] nx, ny, nz, dx, dy, dz, h, a, c, disc, num, tq;
		logic [43:0]        s;
		logic               near, far;
		rec = '0;
		nx = 128'(cen_x) - 128'(signed'(d[23:0]));
		ny = 128'(cen_y) - 128'(signed'(d[47:24]));
		nz = 128'(cen_z) - 128'(signed'(d[71:48]));
		dx = 128'(signed'(d[87:72]));
		dy = 128'(signed'(d[103:88]));
		dz = 128'(signed'(d[119:104]));
		h = dx * nx + dy * ny + dz * nz;
		a = dx * dx + dy * dy + dz * dz;
		c = nx * nx + ny * ny + nz * nz - 128'(radius) * 128'(radius);
		if (a == 0) return rec;
		disc = h * h - a * c;
		if (disc < 0) return rec;
		s = root_floor(disc);
		near = h > 0 && c > 0;
		far = h > 0 || (h == 0 && disc != 0) || (h < 0 && c < 0);
		if (!near && !far) return rec;
		num = near ? h - 128'(s) : h + 128'(s);
		// num is non-negative for the chosen root
		if (num / a >= 1024) tq = 128'hFFFF_FFFF;
		else tq = ((num / a) << 22) + (((num % a) << 22) / a);
		rec.hit = 1'b1;
		rec.distance = tq[31:0];
		if (near) begin
			rec.red = tint(col_r, s);
			rec.green = tint(col_g, s);
			rec.blue = tint(col_b, s);
		end
		return rec;
	endfunction

	assign pending = hits_due.size();

	always @(posedge clk or negedge arst_n) begin
		hit_rec_t want;
		hit_rec_t got;
		if (!arst_n) begin
			cen_x <= '0; cen_y <= '0; cen_z <= '0;
			radius <= 23'd256;
			col_r <= 16'hFFFF; col_g <= 16'hFFFF; col_b <= 16'hFFFF;
			gain <= 16'd256;
			fail_count <= 0;
			hits_due.delete();
		end else begin
			if (s_tvalid && s_tready) hits_due.push_back(trace_light(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata};
				if (hits_due.size() == 0) begin
					$error("hit result with no ray outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = hits_due.pop_front();
					if (got != want) fail_count <= fail_count + 1;
					if (got.hit != want.hit)
						$error("hit: expected %0d actual %0d", want.hit, got.hit);
					if (got.distance != want.distance)
						$error("hit_distance: expected %0h actual %0h", want.distance,
							got.distance);
					if (got.red != want.red)
						$error("out_red: expected %0h actual %0h", want.red, got.red);
					if (got.green != want.green)
						$error("out_green: expected %0h actual %0h", want.green, got.green);
					if (got.blue != want.blue)
						$error("out_blue: expected %0h actual %0h", want.blue, got.blue);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_CENTER_X:  cen_x <= cfg_wdata;
					REG_CENTER_Y:  cen_y <= cfg_wdata;
					REG_CENTER_Z:  cen_z <= cfg_wdata;
					REG_RADIUS:    radius <= cfg_wdata[22:0];
					REG_RED:       col_r <= cfg_wdata[15:0];
					REG_GREEN:     col_g <= cfg_wdata[15:0];
					REG_BLUE:      col_b <= cfg_wdata[15:0];
					REG_INTENSITY: gain <= cfg_wdata[15:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives rays and register writes into the sphere light hit unit under
// random request and result stalls, and reports the checker's verdict.
// ============================================================================
`default_nettype none

module tb_top;
	import rsl_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [InW-1:0]   s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OutW-1:0]  m_tdata;
	logic [0:0]       m_tuser;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_addr = '0;
	logic [PosW-1:0]  cfg_wdata = '0;
	int               fail_count;
	int               pending;
	int               src_idle_pct;
	int               dst_idle_pct;

	always #4 clk = ~clk;

	ray_sphere_light_hit_unit u_dut (.*);

	tb_checker u_chk (.*);

	// result side stalls
	always @(negedge clk) m_tready <= ($urandom_range(99) >= dst_idle_pct);

	task automatic write_reg(input cfg_reg_t idx, input logic [PosW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_ray(input logic [23:0] ox, oy, oz, input logic [15:0] dx, dy, dz);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dz, dy, dx, oz, oy, ox};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (90) @(negedge clk);
	endtask

	task automatic set_light(input logic [23:0] cx, cy, cz, input logic [22:0] rad,
		input logic [15:0] r, g, b, k);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, {1'b0, rad});
		write_reg(REG_RED, {8'd0, r});
		write_reg(REG_GREEN, {8'd0, g});
		write_reg(REG_BLUE, {8'd0, b});
		write_reg(REG_INTENSITY, {8'd0, k});
	endtask

	// mostly rays aimed near the sphere, some fully random
	task automatic random_ray(input int scale);
		logic [23:0] o [3];
		logic [15:0] d [3];
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(3) == 0) begin
				o[k] = 24'($urandom);
				d[k] = 16'($urandom);
			end else begin
				o[k] = 24'($signed($urandom_range(2 * scale)) - scale);
				d[k] = 16'($signed($urandom_range(32768)) - 16384);
			end
		end
		send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endtask

	initial begin
		#2000000;
		$display("ray_sphere_light_hit_unit regression: fail");
		$finish;
	end

	initial begin
		src_idle_pct = 29;
		dst_idle_pct = 46;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset light, unit sphere at origin
		send_ray(24'hFFFC00, 0, 0, 16'h4000, 0, 0);          // near hit from -x
		send_ray(0, 0, 0, 16'h4000, 0, 0);                    // inside, far root
		send_ray(24'h000400, 0, 0, 16'h4000, 0, 0);          // sphere behind
		send_ray(24'hFFFC00, 24'h000400, 0, 16'h4000, 0, 0); // negative discriminant
		send_ray(24'hFFFC00, 0, 0, 0, 0, 0);                  // zero direction
		send_ray(24'hFFFF00, 0, 0, 16'h4000, 0, 0);          // touching surface
		send_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h8000, 16'h8000);
		send_ray(24'h800000, 24'h800000, 24'h800000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_ray(24'h800000, 0, 0, 16'h0001, 0, 0);          // long t saturates
		send_ray(0, 24'hFFFC00, 0, 0, 16'h7FFF, 0);
		send_ray(0, 0, 24'h000400, 0, 0, 16'h8000);
		drain();
		// extremes: huge bright sphere, then zero radius and dark light
		set_light(24'h7FFFFF, 24'h800000, 0, 23'h7FFFFF, 16'hFFFF, 16'h0, 16'h8000, 16'hFFFF);
		send_ray(0, 0, 0, 16'h4000, 16'hC000, 0);
		send_ray(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_ray(24'h800000, 24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 16'h0001);
		drain();
		set_light(24'h800000, 24'h7FFFFF, 24'h800000, 23'd0, 16'h0, 16'hFFFF, 16'h1, 16'h0);
		send_ray(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 0, 0, 16'h4000);
		send_ray(0, 0, 0, 16'h1234, 16'h8765, 16'h7FFF);
		drain();
		write_reg(REG_INTENSITY, 24'h000100);

		// random phases with different lights and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			int sc;
			sc = (ph % 2 == 0) ? 2048 : 8388607;
			src_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 46 : 0;
			dst_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 29 : 0;
			set_light(24'($signed($urandom_range(1024)) - 512),
				24'($signed($urandom_range(1024)) - 512),
				24'($signed($urandom_range(1024)) - 512),
				23'($urandom_range(1, (ph % 2 == 0) ? 1024 : 8388607)),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(65535)));
			for (int i = 0; i < 90; i++) random_ray(sc);
			drain();
		end

		if (fail_count == 0)
			$display("ray_sphere_light_hit_unit regression: pass");
		else
			$display("ray_sphere_light_hit_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
